>>> sv/crs_pkg.sv
package crs_pkg;

	localparam int WINDOW_LEN_DEF = 8;

	localparam int ID_W     = 29;
	localparam int LEN_W    = 4;
	localparam int BITS_W   = 32;
	localparam int RPM_W    = 16;
	localparam int FACTOR_W = 20;
	localparam int THR_W    = 16;
	localparam int SPD_W    = 20;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 29;

	localparam logic [ID_W-1:0]     TARGET_ID_RST = ID_W'(256);
	localparam logic [FACTOR_W-1:0] FACTOR_RST    = FACTOR_W'(65536);
	localparam logic [THR_W-1:0]    THRESH_RST    = THR_W'(10);

	localparam logic [LEN_W-1:0] MIN_PAYLOAD_LEN = LEN_W'(4);

	typedef enum logic {
		ACT_FRAME = 1'b0,
		ACT_TICK  = 1'b1
	} action_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TARGET_ID    = 2'd0,
		REG_SPEED_FACTOR = 2'd1,
		REG_SPEED_THRESH = 2'd2
	} cfg_idx_t;

	// pipeline control between stages
	typedef struct packed {
		logic en;
		logic tick;
	} stage_ctl_t;

endpackage

>>> sv/crs_cell.sv
module crs_cell
	import crs_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             shift,
	input  logic [RPM_W-1:0] din,
	output logic [RPM_W-1:0] dout
);

	logic [RPM_W-1:0] val_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_q <= '0;
		end else if (shift) begin
			val_q <= din;
		end
	end

	assign dout = val_q;

endmodule

>>> sv/crs_window.sv
module crs_window
	import crs_pkg::*;
#(
	parameter int WINDOW_LEN = WINDOW_LEN_DEF,
	parameter int SUM_W      = RPM_W + $clog2(WINDOW_LEN)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  stage_ctl_t       ctl_s1,
	input  logic             push_s1,
	input  logic [RPM_W-1:0] rpm_s1,
	output logic             tick_s2,
	output logic [SUM_W-1:0] sum_s2
);

	logic [RPM_W-1:0] cell_out [WINDOW_LEN];
	logic [SUM_W-1:0] sum_q;
	logic             shift;

	assign shift = ctl_s1.en & push_s1;

	// oldest reading sits in cell 0, newest enters at the far end
	for (genvar i = 0; i < WINDOW_LEN; i++) begin : g_cell
		logic [RPM_W-1:0] din;
		if (i == WINDOW_LEN - 1) begin : g_last
			assign din = rpm_s1;
		end else begin : g_mid
			assign din = cell_out[i+1];
		end
		crs_cell u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.shift (shift),
			.din   (din),
			.dout  (cell_out[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			tick_s2 <= 1'b0;
		end else if (ctl_s1.en) begin
			tick_s2 <= ctl_s1.tick;
			if (push_s1) begin
				sum_q <= sum_q - SUM_W'($signed(cell_out[0])) + SUM_W'($signed(rpm_s1));
			end
		end
	end

	// snapshot of the sum as a tick passes; earlier frames are already in
	always_ff @(posedge clk) begin
		if (ctl_s1.en && ctl_s1.tick) begin
			sum_s2 <= sum_q;
		end
	end

endmodule

>>> sv/crs_avg.sv
module crs_avg
	import crs_pkg::*;
#(
	parameter int WINDOW_LEN = WINDOW_LEN_DEF,
	parameter int SUM_W      = RPM_W + $clog2(WINDOW_LEN)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             tick_s2,
	input  logic [SUM_W-1:0] sum_s2,
	output logic             tick_s4,
	output logic [RPM_W-1:0] avg_s4
);

	// reciprocal estimate is low by at most one for magnitudes below 2^SH
	localparam int SH = SUM_W;
	localparam longint unsigned RECIP_L = (64'd1 << SH) / WINDOW_LEN;
	localparam logic [SH-1:0] RECIP = RECIP_L[SH-1:0];
	localparam logic [SH-1:0] WLEN  = SH'(WINDOW_LEN);

	logic [SH-1:0]   mag;
	logic [2*SH-1:0] prod;
	logic            tick_s3;
	logic            neg_s3;
	logic [SH-1:0]   mag_s3;
	logic [SH-1:0]   q_s3;
	logic [2*SH-1:0] qw;
	logic [SH-1:0]   rem;
	logic [SH-1:0]   q_fix;

	assign mag  = sum_s2[SUM_W-1] ? (~sum_s2 + 1'b1) : sum_s2;
	assign prod = mag * RECIP;

	assign qw    = q_s3 * WLEN;
	assign rem   = mag_s3 - qw[SH-1:0];
	assign q_fix = (rem >= WLEN) ? (q_s3 + 1'b1) : q_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_s3 <= 1'b0;
			tick_s4 <= 1'b0;
		end else if (en) begin
			tick_s3 <= tick_s2;
			tick_s4 <= tick_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s3 <= sum_s2[SUM_W-1];
			mag_s3 <= mag;
			q_s3   <= prod[2*SH-1:SH];
			avg_s4 <= neg_s3 ? RPM_W'(~q_fix + 1'b1) : q_fix[RPM_W-1:0];
		end
	end

endmodule

>>> sv/can_rpm_average_speed_gear.sv
// channel | handshake          | payload
// --------+--------------------+-----------------------------------------------
// in      | in_valid/in_ready  | action, frame_id, payload_len, payload_bits
// out     | out_valid/out_ready| avg_rpm, speed_centi_kmh, gear_drive, *_changed
// cfg     | cfg_we             | cfg_index, cfg_data
//
// One word accepted per cycle while in_ready is high. A tick's result word passes
// the float decode, window row, two divide stages, rpm compare with the speed
// multiply, speed scaling and output register, the first loaded on the accepting
// edge; frames give no result.
// Reset clears the window cells, running sum, shown values and control flags.
// in_ready drops only while a tick waits in the last stage and the output
// register still holds an untaken word.
module can_rpm_average_speed_gear
	import crs_pkg::*;
#(
	parameter int WINDOW_LEN = WINDOW_LEN_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  action,
	input  logic [ID_W-1:0]       frame_id,
	input  logic [LEN_W-1:0]      payload_len,
	input  logic [BITS_W-1:0]     payload_bits,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic signed [RPM_W-1:0] avg_rpm,
	output logic signed [SPD_W-1:0] speed_centi_kmh,
	output logic                  gear_drive,
	output logic                  rpm_changed,
	output logic                  speed_changed,
	output logic                  gear_changed,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int SUM_W  = RPM_W + $clog2(WINDOW_LEN);
	localparam int PROD_W = RPM_W + FACTOR_W + 1;
	localparam int QUO_W  = PROD_W - 16;
	localparam int DIFF_W = SPD_W + 1;

	localparam logic signed [QUO_W-1:0] SPD_MAX = QUO_W'(524287);
	localparam logic signed [QUO_W-1:0] SPD_MIN = -QUO_W'(524288);

	function automatic logic [RPM_W-1:0] float_to_rpm(input logic [BITS_W-1:0] b);
		logic [7:0]       expo;
		logic [22:0]      mant;
		logic [23:0]      full;
		logic [4:0]       sh;
		logic [RPM_W-1:0] mag;
		logic [RPM_W-1:0] res;
		expo = b[30:23];
		mant = b[22:0];
		full = {1'b1, mant};
		sh   = 5'(8'd150 - expo);
		mag  = RPM_W'(full >> sh);
		if (expo == 8'hFF && mant != '0) begin
			res = '0;
		end else if (expo >= 8'd142) begin
			res = b[31] ? 16'h8000 : 16'h7FFF;
		end else if (expo < 8'd127) begin
			res = '0;
		end else begin
			res = b[31] ? (~mag + 1'b1) : mag;
		end
		return res;
	endfunction

	logic [ID_W-1:0]     target_q;
	logic [FACTOR_W-1:0] factor_q;
	logic [THR_W-1:0]    thresh_q;

	logic en;
	logic accept;

	logic             tick_s1;
	logic             push_s1;
	logic [RPM_W-1:0] rpm_s1;
	stage_ctl_t       ctl_s1;

	logic             tick_s2;
	logic [SUM_W-1:0] sum_s2;
	logic             tick_s4;
	logic [RPM_W-1:0] avg_s4;

	logic [RPM_W-1:0] shown_rpm_q;
	logic             drive_q;
	logic [SPD_W-1:0] shown_speed_q;

	logic                     tick_s5;
	logic                     upd_s5;
	logic                     gear_chg_s5;
	logic signed [PROD_W-1:0] prod_s5;

	logic             tick_s6;
	logic             upd_s6;
	logic             gear_chg_s6;
	logic [SPD_W-1:0] spd_s6;
	logic [RPM_W-1:0] rpm_s6;
	logic             drive_s6;

	logic                     avg_drive;
	logic signed [PROD_W-1:0] prod_adj;
	logic signed [QUO_W-1:0]  quo;
	logic [SPD_W-1:0]         spd_sat;
	logic signed [DIFF_W-1:0] diff;
	logic [DIFF_W-1:0]        diff_abs;
	logic                     spd_move;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= TARGET_ID_RST;
			factor_q <= FACTOR_RST;
			thresh_q <= THRESH_RST;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				REG_TARGET_ID:    target_q <= cfg_data[ID_W-1:0];
				REG_SPEED_FACTOR: factor_q <= cfg_data[FACTOR_W-1:0];
				REG_SPEED_THRESH: thresh_q <= cfg_data[THR_W-1:0];
				default:          ;
			endcase
		end
	end

	// the whole pipe holds only when a tick must enter a full output register
	assign en       = !(tick_s6 && out_valid && !out_ready);
	assign in_ready = en;
	assign accept   = in_valid && en;

	// stage 1: decode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_s1 <= 1'b0;
			push_s1 <= 1'b0;
		end else if (en) begin
			tick_s1 <= accept && (action_t'(action) == ACT_TICK);
			push_s1 <= accept && (action_t'(action) == ACT_FRAME) &&
				(frame_id == target_q) && (payload_len >= MIN_PAYLOAD_LEN);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rpm_s1 <= float_to_rpm(payload_bits);
		end
	end

	assign ctl_s1 = '{en: en, tick: tick_s1};

	crs_window #(
		.WINDOW_LEN(WINDOW_LEN),
		.SUM_W     (SUM_W)
	) u_window (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl_s1 (ctl_s1),
		.push_s1(push_s1),
		.rpm_s1 (rpm_s1),
		.tick_s2(tick_s2),
		.sum_s2 (sum_s2)
	);

	crs_avg #(
		.WINDOW_LEN(WINDOW_LEN),
		.SUM_W     (SUM_W)
	) u_avg (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.tick_s2(tick_s2),
		.sum_s2 (sum_s2),
		.tick_s4(tick_s4),
		.avg_s4 (avg_s4)
	);

	// stage 5: compare with shown rpm, gear, speed multiply
	assign avg_drive = !avg_s4[RPM_W-1] && (avg_s4 != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_s5     <= 1'b0;
			upd_s5      <= 1'b0;
			gear_chg_s5 <= 1'b0;
			shown_rpm_q <= '0;
			drive_q     <= 1'b0;
		end else if (en) begin
			tick_s5     <= tick_s4;
			upd_s5      <= 1'b0;
			gear_chg_s5 <= 1'b0;
			if (tick_s4 && (avg_s4 != shown_rpm_q)) begin
				upd_s5      <= 1'b1;
				shown_rpm_q <= avg_s4;
				drive_q     <= avg_drive;
				gear_chg_s5 <= (avg_drive != drive_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s5 <= $signed(avg_s4) * $signed({1'b0, factor_q});
		end
	end

	// stage 6: divide by 65536 toward zero, saturate
	assign prod_adj = prod_s5 + (prod_s5[PROD_W-1] ? PROD_W'(65535) : '0);
	assign quo      = QUO_W'(prod_adj >>> 16);
	assign spd_sat  = (quo > SPD_MAX) ? SPD_MAX[SPD_W-1:0] :
		(quo < SPD_MIN) ? SPD_MIN[SPD_W-1:0] : quo[SPD_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_s6     <= 1'b0;
			upd_s6      <= 1'b0;
			gear_chg_s6 <= 1'b0;
		end else if (en) begin
			tick_s6     <= tick_s5;
			upd_s6      <= upd_s5;
			gear_chg_s6 <= gear_chg_s5;
		end
	end

	// shown rpm and gear travel with the tick; a tick right behind may update them
	always_ff @(posedge clk) begin
		if (en) begin
			spd_s6   <= spd_sat;
			rpm_s6   <= shown_rpm_q;
			drive_s6 <= drive_q;
		end
	end

	// stage 7: threshold against shown speed, output word
	assign diff     = DIFF_W'($signed(spd_s6)) - DIFF_W'($signed(shown_speed_q));
	assign diff_abs = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
	assign spd_move = upd_s6 && (diff_abs > DIFF_W'(thresh_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid     <= 1'b0;
			shown_speed_q <= '0;
		end else if (en) begin
			if (tick_s6) begin
				out_valid <= 1'b1;
				if (spd_move) begin
					shown_speed_q <= spd_s6;
				end
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en && tick_s6) begin
			avg_rpm         <= rpm_s6;
			speed_centi_kmh <= spd_move ? spd_s6 : shown_speed_q;
			gear_drive      <= drive_s6;
			rpm_changed     <= upd_s6;
			speed_changed   <= spd_move;
			gear_changed    <= gear_chg_s6;
		end
	end

endmodule

>>> test/tb_can_rpm_average_speed_gear.sv
`timescale 1ns / 100ps

module tb_can_rpm_average_speed_gear;
	import crs_pkg::*;

	localparam int WIN = WINDOW_LEN_DEF;
	localparam int WORDS_PER_PHASE = 228;
	localparam int NUM_PHASES = 8;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	typedef struct packed {
		logic signed [RPM_W-1:0] rpm;
		logic signed [SPD_W-1:0] spd;
		logic drive;
		logic rpm_chg;
		logic spd_chg;
		logic gear_chg;
	} dash_t;

	typedef struct packed {
		action_t act;
		logic [ID_W-1:0] id;
		logic [LEN_W-1:0] len;
		logic [BITS_W-1:0] bits;
		logic typed;
		dash_t want;
	} stim_row_t;

	localparam dash_t NO_DASH = '0;
	localparam logic [ID_W-1:0] TID = TARGET_ID_RST;

	// directed words; typed results only where they are obvious
	localparam stim_row_t DIR_ROWS [24] = '{
		'{ACT_TICK,  TID,          4'd0,  32'h0000_0000, 1'b1, NO_DASH},
		'{ACT_FRAME, TID,          4'd3,  32'h447A_0000, 1'b0, NO_DASH},  // too short
		'{ACT_FRAME, TID + 29'd1,  4'd4,  32'h447A_0000, 1'b0, NO_DASH},  // other id
		'{ACT_TICK,  TID,          4'd0,  32'h0000_0000, 1'b1, NO_DASH},
		'{ACT_FRAME, TID,          4'd4,  32'h7FC0_0000, 1'b0, NO_DASH},  // NaN
		'{ACT_FRAME, TID,          4'd15, 32'h7F80_0000, 1'b0, NO_DASH},  // +inf, long len
		'{ACT_FRAME, TID,          4'd8,  32'h4700_0000, 1'b0, NO_DASH},  // 32768.0
		'{ACT_FRAME, TID,          4'd4,  32'h3F7F_FFFF, 1'b0, NO_DASH},  // just below 1
		'{ACT_FRAME, TID,          4'd4,  32'hBFC0_0000, 1'b0, NO_DASH},  // -1.5
		'{ACT_TICK,  TID,          4'd0,  32'h0000_0000, 1'b1,
			'{16'sd8191, 20'sd8191, 1'b1, 1'b1, 1'b1, 1'b1}},
		'{ACT_TICK,  TID,          4'd0,  32'h0000_0000, 1'b1,
			'{16'sd8191, 20'sd8191, 1'b1, 1'b0, 1'b0, 1'b0}},
		'{ACT_FRAME, TID,          4'd4,  32'hFF80_0000, 1'b0, NO_DASH},  // -inf
		'{ACT_FRAME, TID,          4'd4,  32'hC700_0000, 1'b0, NO_DASH},  // -32768.0
		'{ACT_FRAME, TID,          4'd4,  32'hC6FF_FE00, 1'b0, NO_DASH},  // -32767.0
		'{ACT_FRAME, TID,          4'd4,  32'hFFFF_FFFF, 1'b0, NO_DASH},  // negative NaN
		'{ACT_FRAME, TID,          4'd4,  32'h0000_0001, 1'b0, NO_DASH},  // denormal
		'{ACT_FRAME, TID,          4'd4,  32'h8000_0000, 1'b0, NO_DASH},  // -0.0
		'{ACT_TICK,  TID,          4'd0,  32'h0000_0000, 1'b0, NO_DASH},
		'{ACT_FRAME, 29'h1FFF_FFFF, 4'd4,  32'h46FF_FE00, 1'b0, NO_DASH},
		'{ACT_FRAME, 29'h0,        4'd0,  32'h0000_0000, 1'b0, NO_DASH},
		'{ACT_FRAME, TID,          4'd4,  32'h46FF_FE00, 1'b0, NO_DASH},  // 32767.0
		'{ACT_FRAME, TID,          4'd4,  32'h4B00_0000, 1'b0, NO_DASH},  // 2^23
		'{ACT_TICK,  TID,          4'd0,  32'h0000_0000, 1'b0, NO_DASH},
		'{ACT_TICK,  29'h1FFF_FFFF, 4'd15, 32'hFFFF_FFFF, 1'b0, NO_DASH}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic action = ACT_FRAME;
	logic [ID_W-1:0] frame_id = '0;
	logic [LEN_W-1:0] payload_len = '0;
	logic [BITS_W-1:0] payload_bits = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [RPM_W-1:0] avg_rpm;
	logic signed [SPD_W-1:0] speed_centi_kmh;
	logic gear_drive;
	logic rpm_changed;
	logic speed_changed;
	logic gear_changed;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// predictor state and its copy of the registers
	logic [ID_W-1:0] cur_target = TARGET_ID_RST;
	longint cur_factor = FACTOR_RST;
	longint cur_thresh = THRESH_RST;
	int rpm_win [WIN];
	int win_sum = 0;
	int shown_rpm = 0;
	int shown_speed = 0;
	bit drive_on = 1'b0;

	dash_t dash_q [$];
	int words_taken = 0;
	int fail_cnt = 0;
	bit idle_on = 1'b1;
	bit use_typed = 1'b0;
	dash_t typed_dash = '0;

	can_rpm_average_speed_gear dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.action(action),
		.frame_id(frame_id),
		.payload_len(payload_len),
		.payload_bits(payload_bits),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.avg_rpm(avg_rpm),
		.speed_centi_kmh(speed_centi_kmh),
		.gear_drive(gear_drive),
		.rpm_changed(rpm_changed),
		.speed_changed(speed_changed),
		.gear_changed(gear_changed),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	function automatic int float_to_rpm(logic [31:0] b);
		logic [7:0] expo;
		logic [22:0] mant;
		int mag;
		expo = b[30:23];
		mant = b[22:0];
		if (expo == 8'hFF && mant != 0)
			return 0;
		if (expo >= 8'd142)
			return b[31] ? -32768 : 32767;
		if (expo < 8'd127)
			return 0;
		mag = int'({8'd0, 1'b1, mant} >> (150 - expo));
		return b[31] ? -mag : mag;
	endfunction

	task automatic cluster_step(input logic act, input logic [ID_W-1:0] id,
			input logic [LEN_W-1:0] len, input logic [BITS_W-1:0] bits,
			output dash_t res, output bit has_res);
		int rpm;
		int avg;
		longint spd;
		longint diff;
		bit rchg;
		bit schg;
		bit gchg;
		rchg = 0;
		schg = 0;
		gchg = 0;
		has_res = 0;
		res = '0;
		if (act == ACT_FRAME) begin
			if (id == cur_target && len >= MIN_PAYLOAD_LEN) begin
				rpm = float_to_rpm(bits);
				win_sum = win_sum - rpm_win[0];
				for (int i = 0; i < WIN - 1; i++)
					rpm_win[i] = rpm_win[i + 1];
				rpm_win[WIN - 1] = rpm;
				win_sum = win_sum + rpm;
			end
		end else begin
			avg = win_sum / WIN;
			if (avg != shown_rpm) begin
				shown_rpm = avg;
				rchg = 1;
				spd = (longint'(shown_rpm) * cur_factor) / 65536;
				if (spd > 524287)
					spd = 524287;
				if (spd < -524288)
					spd = -524288;
				diff = spd - shown_speed;
				if (diff < 0)
					diff = -diff;
				if (diff > cur_thresh) begin
					shown_speed = int'(spd);
					schg = 1;
				end
				if ((shown_rpm > 0) != drive_on) begin
					drive_on = shown_rpm > 0;
					gchg = 1;
				end
			end
			res.rpm = shown_rpm[RPM_W-1:0];
			res.spd = shown_speed[SPD_W-1:0];
			res.drive = drive_on;
			res.rpm_chg = rchg;
			res.spd_chg = schg;
			res.gear_chg = gchg;
			has_res = 1;
		end
	endtask

	always @(posedge clk) begin : watch
		dash_t pred;
		dash_t got;
		dash_t want;
		bit has;
		if (arst_n) begin
			if (cfg_we) begin
				case (cfg_index)
					REG_TARGET_ID: cur_target = cfg_data[ID_W-1:0];
					REG_SPEED_FACTOR: cur_factor = cfg_data[FACTOR_W-1:0];
					REG_SPEED_THRESH: cur_thresh = cfg_data[THR_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				cluster_step(action, frame_id, payload_len, payload_bits, pred, has);
				if (has)
					dash_q.push_back(use_typed ? typed_dash : pred);
				words_taken++;
			end
			if (out_valid && out_ready) begin
				got = {avg_rpm, speed_centi_kmh, gear_drive, rpm_changed, speed_changed,
					gear_changed};
				if (dash_q.size() == 0) begin
					if (fail_cnt < 10)
						$display("%0t: unexpected word rpm %0d speed %0d", $realtime,
							avg_rpm, speed_centi_kmh);
					fail_cnt++;
				end else begin
					want = dash_q.pop_front();
					if (got.rpm !== want.rpm || got.spd !== want.spd ||
							got.drive !== want.drive || got.rpm_chg !== want.rpm_chg ||
							got.spd_chg !== want.spd_chg || got.gear_chg !== want.gear_chg) begin
						if (fail_cnt < 10)
							$display("%0t: mismatch exp rpm %0d spd %0d d%b c%b%b%b, got rpm %0d spd %0d d%b c%b%b%b",
								$realtime, want.rpm, want.spd, want.drive, want.rpm_chg,
								want.spd_chg, want.gear_chg, got.rpm, got.spd, got.drive,
								got.rpm_chg, got.spd_chg, got.gear_chg);
						fail_cnt++;
					end
				end
			end
		end
	end

	// receiver stalls
	always @(negedge clk)
		out_ready = !(idle_on && $urandom_range(99) < 31);

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic send_word(input action_t act, input logic [ID_W-1:0] id,
			input logic [LEN_W-1:0] len, input logic [BITS_W-1:0] bits);
		int taken0;
		while (idle_on && $urandom_range(99) < 31) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		action = act;
		frame_id = id;
		payload_len = len;
		payload_bits = bits;
		in_valid = 1'b1;
		taken0 = words_taken;
		do
			@(negedge clk);
		while (words_taken == taken0);
	endtask

	task automatic send_random_word();
		int r;
		logic [ID_W-1:0] id;
		logic [LEN_W-1:0] len;
		logic [BITS_W-1:0] bits;
		id = ID_W'($urandom);
		len = LEN_W'($urandom);
		bits = $urandom;
		if ($urandom_range(99) < 25) begin
			send_word(ACT_TICK, id, len, bits);
		end else begin
			r = $urandom_range(99);
			if (r < 80)
				id = cur_target;
			else if (r < 90)
				id = cur_target ^ (ID_W'(1) << $urandom_range(ID_W - 1));
			if ($urandom_range(99) < 85)
				len = LEN_W'($urandom_range(8, 4));
			r = $urandom_range(99);
			if (r < 75) begin
				// plausible readings, mostly positive, some past the rpm range
				bits = {$urandom_range(99) < 20, 8'($urandom_range(146, 118)),
					23'($urandom)};
			end else if (r < 88) begin
				case ($urandom_range(3))
					0: bits = {$urandom_range(1) == 1, 8'hFF, 23'd0};
					1: bits = {$urandom_range(1) == 1, 8'hFF, 23'($urandom) | 23'd1};
					2: bits = {$urandom_range(1) == 1, 31'd0};
					default: bits = {$urandom_range(1) == 1, 8'd0, 23'($urandom)};
				endcase
			end
			send_word(ACT_FRAME, id, len, bits);
		end
	endtask

	task automatic drain();
		in_valid = 1'b0;
		while (dash_q.size() != 0)
			@(negedge clk);
	endtask

	task automatic settle();
		drain();
		repeat (12) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	initial begin
		for (int i = 0; i < WIN; i++)
			rpm_win[i] = 0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (DIR_ROWS[i]) begin
			use_typed = DIR_ROWS[i].typed;
			typed_dash = DIR_ROWS[i].want;
			send_word(DIR_ROWS[i].act, DIR_ROWS[i].id, DIR_ROWS[i].len, DIR_ROWS[i].bits);
		end
		use_typed = 1'b0;

		for (int p = 0; p < NUM_PHASES; p++) begin
			settle();
			idle_on = (p != 3);
			case (p)
				0: ;  // reset values
				1: begin
					write_reg(REG_TARGET_ID, '0);
					write_reg(REG_SPEED_FACTOR, '0);
					write_reg(REG_SPEED_THRESH, '0);
				end
				2: begin
					write_reg(REG_TARGET_ID, {CFG_DATA_W{1'b1}});
					write_reg(REG_SPEED_FACTOR, CFG_DATA_W'(20'hFFFFF));
					write_reg(REG_SPEED_THRESH, CFG_DATA_W'(16'hFFFF));
				end
				3: begin
					write_reg(REG_TARGET_ID, CFG_DATA_W'($urandom));
					write_reg(REG_SPEED_FACTOR, CFG_DATA_W'(FACTOR_RST));
					write_reg(REG_SPEED_THRESH, '0);
				end
				5: begin
					write_reg(REG_TARGET_ID, CFG_DATA_W'($urandom));
					write_reg(REG_SPEED_FACTOR, CFG_DATA_W'(20'hFFFFF));
					write_reg(REG_SPEED_THRESH, '0);
				end
				7: begin
					write_reg(REG_TARGET_ID, CFG_DATA_W'(TARGET_ID_RST));
					write_reg(REG_SPEED_FACTOR, CFG_DATA_W'($urandom_range(200000)));
					write_reg(REG_SPEED_THRESH, CFG_DATA_W'($urandom_range(50)));
				end
				default: begin
					// upper data bits beyond each register are dropped
					write_reg(REG_TARGET_ID, CFG_DATA_W'($urandom));
					write_reg(REG_SPEED_FACTOR, CFG_DATA_W'($urandom));
					write_reg(REG_SPEED_THRESH, CFG_DATA_W'($urandom));
					write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
				end
			endcase
			for (int k = 0; k < WORDS_PER_PHASE; k++) begin
				if (k == WORDS_PER_PHASE / 2)
					drain();
				send_random_word();
			end
		end

		drain();
		repeat (20) @(negedge clk);
		if (fail_cnt == 0 && dash_q.size() == 0)
			$display("tb_can_rpm_average_speed_gear: PASS");
		else
			$display("tb_can_rpm_average_speed_gear: FAIL");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("tb_can_rpm_average_speed_gear: FAIL");
		$finish;
	end

endmodule
